@@ hdl/coverage_marker_selector_macros.svh @@
// assertion macros used by the coverage marker selector checker
`ifndef COVERAGE_MARKER_SELECTOR_MACROS_SVH
`define COVERAGE_MARKER_SELECTOR_MACROS_SVH

// clocked property with reset disable and a fixed message
`define CMS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cms checker: property violated");

// clocked property with reset disable and a caller message
`define CMS_ASSERT_MSG(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

`endif

@@ hdl/cms_pkg.sv @@
// constants and token type of the coverage marker selector
`timescale 1ns / 1ps

package cms_pkg;

  // read length limit and number of candidate values
  localparam int MAX_POSITIONS = 4096;
  localparam int CANDIDATES    = 10;

  // field widths
  localparam int COV_W   = 16;
  localparam int POS_W   = $clog2(MAX_POSITIONS);
  localparam int CNT_W   = $clog2(MAX_POSITIONS + 1);
  localparam int SCORE_W = CNT_W + 1;
  localparam int CAND_W  = $clog2(CANDIDATES + 1);
  localparam int THR_W   = CAND_W + 1;

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((COV_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + POS_W + POS_W + THR_W + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // token handed from cell to cell along the chain
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               cnt_en;
    logic [COV_W-1:0]   cov;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic               ovf;
    logic               best_vld;
    logic               best_found;
    logic [CAND_W-1:0]  best_cand;
    logic [SCORE_W-1:0] best_score;
    logic [POS_W-1:0]   best_first;
    logic [POS_W-1:0]   best_last;
  } cms_token_t;

endpackage

@@ hdl/coverage_marker_selector.sv @@
// coverage marker selector: top level with position head, cell chain and result register
//
// Input stream: one k-mer coverage value per transaction, tlast on the final
// value of a read. Output stream: one result transaction per read, carrying
// found flag, forward index, reverse offset, chosen threshold, position count
// and the too-long flag.
// Each value walks a chain of one cell per candidate value, largest first;
// every cell updates its own counts as the value passes and, on the last
// value, compares its score with the best handed in by its neighbor.
// Throughput: one value per cycle, the input is taken in every cycle the
// output register is empty or being drained.
// The last value of a read reaches its result through the head register,
// one register per cell and the result register.
// Reset clears the position counter, all cell counters and hit marks and the
// pipeline; no clearing pass follows, the block is ready once reset is released.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready_o drops until the result is taken.
`timescale 1ns / 1ps

module coverage_marker_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [cms_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // [15:0] coverage
  input  logic                             s_axis_tlast_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] found, [12:1] forward_index, [24:13] reverse_offset,
  // [29:25] chosen_threshold, [42:30] position_count, [43] too_long
  output logic [cms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import cms_pkg::*;

  logic       adv;
  logic       out_vld;
  cms_token_t tok [CANDIDATES+1];

  // chain moves whenever the result register can take a new result
  assign adv             = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld;

  // position tagging
  cms_head u_head (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_axis_tvalid_i),
    .cov_i  (s_axis_tdata_i[COV_W-1:0]),
    .last_i (s_axis_tlast_i),
    .tok_o  (tok[0])
  );

  // candidate cells, largest candidate value first
  for (genvar i = 0; i < CANDIDATES; i++) begin : g_cell
    cms_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cand_i (CAND_W'(CANDIDATES - i)),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // result register
  cms_tail u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .tok_i  (tok[CANDIDATES]),
    .vld_o  (out_vld),
    .data_o (m_axis_tdata_o)
  );

endmodule

@@ hdl/cms_head.sv @@
// position counter that tags each coverage value before the cell chain
`timescale 1ns / 1ps

module cms_head (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        vld_i,
  input  logic [cms_pkg::COV_W-1:0]   cov_i,
  input  logic                        last_i,
  output cms_pkg::cms_token_t         tok_o
);
  import cms_pkg::*;

  logic [CNT_W-1:0] pos_q, pos_d;
  logic             ovf_q, ovf_d;
  logic             cnt_en;
  logic [CNT_W-1:0] count_n;
  logic             ovf_n;
  cms_token_t       tok_q, tok_d;

  // position bookkeeping for the incoming value
  always_comb begin
    cnt_en  = (pos_q < CNT_W'(MAX_POSITIONS));
    count_n = cnt_en ? pos_q + CNT_W'(1) : pos_q;
    ovf_n   = ovf_q | ~cnt_en;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    if (vld_i && adv_i) begin
      if (last_i) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end else begin
        pos_d = count_n;
        ovf_d = ovf_n;
      end
    end
  end

  // token built for the first cell
  always_comb begin
    tok_d            = '0;
    tok_d.vld        = vld_i;
    tok_d.last       = last_i;
    tok_d.cnt_en     = cnt_en;
    tok_d.cov        = cov_i;
    tok_d.pos        = pos_q[POS_W-1:0];
    tok_d.count      = count_n;
    tok_d.ovf        = ovf_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
      tok_q <= '0;
    end else begin
      pos_q <= pos_d;
      ovf_q <= ovf_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/cms_cell.sv @@
// one candidate cell: bin counts, hit positions and running best choice
`timescale 1ns / 1ps

module cms_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [cms_pkg::CAND_W-1:0]  cand_i,
  input  cms_pkg::cms_token_t         tok_i,
  output cms_pkg::cms_token_t         tok_o
);
  import cms_pkg::*;

  logic [CNT_W-1:0]   low_q, low_d, low_n;
  logic [CNT_W-1:0]   high_q, high_d, high_n;
  logic [POS_W-1:0]   first_q, first_d, first_n;
  logic [POS_W-1:0]   last_q, last_d, last_n;
  logic               hit_q, hit_d, hit_n;
  logic               upd, is_low, is_high, take;
  logic [SCORE_W-1:0] score;
  cms_token_t         tok_q, tok_d;

  // compare against v and 2v, fold in the current value
  always_comb begin
    upd     = tok_i.vld & tok_i.cnt_en;
    is_low  = (tok_i.cov <= COV_W'(cand_i));
    is_high = (tok_i.cov >= COV_W'({cand_i, 1'b0}));
    low_n   = low_q + CNT_W'(upd & is_low);
    high_n  = high_q + CNT_W'(upd & is_high);
    hit_n   = hit_q | (upd & is_high);
    first_n = (!hit_q && upd && is_high) ? tok_i.pos : first_q;
    last_n  = (upd && is_high) ? tok_i.pos : last_q;
    score   = {1'b0, low_n} + {1'b0, high_n};
    take    = !tok_i.best_vld || (score > tok_i.best_score);
  end

  // state update, cleared after the last value of a read
  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    first_d = first_q;
    last_d  = last_q;
    hit_d   = hit_q;
    if (adv_i && tok_i.vld) begin
      if (tok_i.last) begin
        low_d   = '0;
        high_d  = '0;
        first_d = '0;
        last_d  = '0;
        hit_d   = 1'b0;
      end else begin
        low_d   = low_n;
        high_d  = high_n;
        first_d = first_n;
        last_d  = last_n;
        hit_d   = hit_n;
      end
    end
  end

  // pass the token on, taking over the best slot when it is empty or on a strictly higher score
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && tok_i.last && take) begin
      tok_d.best_vld   = 1'b1;
      tok_d.best_found = hit_n;
      tok_d.best_cand  = cand_i;
      tok_d.best_score = score;
      tok_d.best_first = first_n;
      tok_d.best_last  = last_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      hit_q   <= 1'b0;
      tok_q   <= '0;
    end else begin
      low_q   <= low_d;
      high_q  <= high_d;
      first_q <= first_d;
      last_q  <= last_d;
      hit_q   <= hit_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hdl/cms_tail.sv @@
// result register: offsets, threshold and packing of the output transaction
`timescale 1ns / 1ps

module cms_tail (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  cms_pkg::cms_token_t              tok_i,
  output logic                             vld_o,
  output logic [cms_pkg::OUT_TDATA_W-1:0]  data_o
);
  import cms_pkg::*;

  logic                   vld_q, vld_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]       rev_full;
  logic [POS_W-1:0]       fwd, rev;
  logic [THR_W-1:0]       thr;

  // forward index and reverse offset of the chosen candidate
  always_comb begin
    rev_full = tok_i.count - CNT_W'(1) - {1'b0, tok_i.best_last};
    fwd      = tok_i.best_found ? tok_i.best_first : '0;
    rev      = tok_i.best_found ? rev_full[POS_W-1:0] : '0;
    thr      = {tok_i.best_cand, 1'b0};
    data_d   = OUT_TDATA_W'({tok_i.ovf, tok_i.count, thr, rev, fwd, tok_i.best_found});
    vld_d    = vld_q;
    if (adv_i) begin
      vld_d = tok_i.vld & tok_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload loads only with a finished read
  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.vld && tok_i.last) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

@@ hdl/cms_checker.sv @@
// port-level checker of the coverage marker selector and its bind
`timescale 1ns / 1ps
`include "coverage_marker_selector_macros.svh"

module cms_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             out_tvalid_i,
  input  logic                             out_tready_i,
  input  logic [cms_pkg::OUT_TDATA_W-1:0]  out_tdata_i
);
  import cms_pkg::*;

  logic             found;
  logic [POS_W-1:0] fwd;
  logic [POS_W-1:0] rev;
  logic [THR_W-1:0] thr;
  logic [CNT_W-1:0] count;
  logic             too_long;
  logic [CNT_W-1:0] span;

  // unpack the result fields
  assign found    = out_tdata_i[0];
  assign fwd      = out_tdata_i[POS_W:1];
  assign rev      = out_tdata_i[2*POS_W:POS_W+1];
  assign thr      = out_tdata_i[2*POS_W+THR_W:2*POS_W+1];
  assign count    = out_tdata_i[2*POS_W+THR_W+CNT_W:2*POS_W+THR_W+1];
  assign too_long = out_tdata_i[2*POS_W+THR_W+CNT_W+1];
  assign span     = {1'b0, fwd} + {1'b0, rev};

  // a stalled result holds
  `CMS_ASSERT(a_out_hold, clk_i, rst_ni,
    out_tvalid_i && !out_tready_i |=> out_tvalid_i && $stable(out_tdata_i))

  // threshold is twice a candidate value
  `CMS_ASSERT_MSG(a_thr_range, clk_i, rst_ni,
    out_tvalid_i |-> !thr[0] && thr != '0 && thr <= THR_W'(2 * CANDIDATES),
    "cms checker: threshold out of range")

  // nothing found means zero offsets
  `CMS_ASSERT(a_not_found_zero, clk_i, rst_ni,
    out_tvalid_i && !found |-> fwd == '0 && rev == '0)

  // counts stay within the read length limit
  `CMS_ASSERT_MSG(a_count_range, clk_i, rst_ni,
    out_tvalid_i |-> count != '0 && count <= CNT_W'(MAX_POSITIONS) &&
      (!too_long || count == CNT_W'(MAX_POSITIONS)),
    "cms checker: position count out of range")

  // first and last hit lie inside the read
  `CMS_ASSERT(a_hits_inside, clk_i, rst_ni,
    out_tvalid_i && found |-> span < count)

endmodule

bind coverage_marker_selector cms_checker u_cms_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_tvalid_i (m_axis_tvalid_o),
  .out_tready_i (m_axis_tready_i),
  .out_tdata_i  (m_axis_tdata_o)
);
